FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("assertion failed");

// Clocked assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/core/ske_pkg.sv
// Shared types and constants of the sequence-keyed LSB embedder.
// Used by the embed datapath, the top level and the port checker.
package ske_pkg;

  // Field widths of the configuration registers and the stream payload.
  localparam int KEY_CODES_W   = 64;
  localparam int KEY_LEN_W     = 6;
  localparam int DIM_W         = 16;
  localparam int MSG_BYTES_W   = 29;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int CHAN_W        = 8;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 24;
  localparam int OUT_TUSER_W   = 2;
  localparam int BITS_LEFT_W   = 4;

  // Default depth of the key sequence.
  localparam int MAX_KEY_CODES_DEF = 32;

  // A fresh message byte holds this many bits to place.
  localparam logic [BITS_LEFT_W-1:0] BYTE_BITS = 4'd8;

  // Item kinds carried on the input tuser bit.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KEY_CODES     = 3'd0,
    REG_KEY_LENGTH    = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_IMAGE_HEIGHT  = 3'd3,
    REG_MESSAGE_BYTES = 3'd4
  } cfg_reg_t;

  // Control handed to the embed datapath for one pixel.
  typedef struct packed {
    logic       place;    // a message bit goes into this pixel
    logic       bit_val;  // the message bit
    logic [1:0] code;     // key code: selects channel and bit position
  } embed_ctl_t;

endpackage

FILE: rtl/core/ske_embed.sv
// Pixel datapath of the embedder: writes one message bit into one channel.
// Depends on ske_pkg for the channel width and the embed control struct.
module ske_embed (
  input  logic [ske_pkg::CHAN_W-1:0] chan_zero,
  input  logic [ske_pkg::CHAN_W-1:0] chan_one,
  input  logic [ske_pkg::CHAN_W-1:0] chan_two,
  input  ske_pkg::embed_ctl_t        ctl,
  output logic [ske_pkg::CHAN_W-1:0] res_zero,
  output logic [ske_pkg::CHAN_W-1:0] res_one,
  output logic [ske_pkg::CHAN_W-1:0] res_two
);

  logic [ske_pkg::CHAN_W-1:0] mask;
  logic                       sel_zero;
  logic                       sel_one;
  logic                       sel_two;

  // Bit 0 of the code set picks bit position 0, otherwise position 1.
  assign mask = ctl.code[0] ? ske_pkg::CHAN_W'(1) : ske_pkg::CHAN_W'(2);

  // Bit 1 set picks channel 2; otherwise bit 0 is the channel number.
  assign sel_two  = ctl.place && ctl.code[1];
  assign sel_one  = ctl.place && !ctl.code[1] && ctl.code[0];
  assign sel_zero = ctl.place && !ctl.code[1] && !ctl.code[0];

  // Set or clear the chosen bit; other channels pass unchanged.
  always_comb begin
    res_zero = chan_zero;
    res_one  = chan_one;
    res_two  = chan_two;
    if (sel_zero) begin
      res_zero = ctl.bit_val ? (chan_zero | mask) : (chan_zero & ~mask);
    end
    if (sel_one) begin
      res_one = ctl.bit_val ? (chan_one | mask) : (chan_one & ~mask);
    end
    if (sel_two) begin
      res_two = ctl.bit_val ? (chan_two | mask) : (chan_two & ~mask);
    end
  end

endmodule

FILE: rtl/core/sequence_keyed_lsb_embedder.sv
// Sequence-keyed LSB embedder: hides message bits in a stream of RGB pixels.
// Depends on ske_pkg and instantiates ske_embed for the pixel datapath.
//
// The input stream carries two kinds of word, told apart by in_tuser: a
// message byte (0) or a pixel (1). A byte word loads the byte, whose bits are
// then spent MSB first, one per following pixel; it gives no output word.
// Each pixel gives exactly one output word with the three channels, a flag
// that a bit was placed and a flag that the message exceeds the image.
// Key codes cycle through the first key_length entries of key_codes and
// pick channel and bit position for every placed bit.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// do this only while the stream is idle, which the block does not enforce.
// The capacity check reads the registers directly. A pixel accepted at an
// edge is in the output register right after that edge. Throughput: one word
// per cycle, limited only by the output register, which holds a result while
// the receiver stalls; a new word enters in the same cycle the result leaves.
// Reset (synchronous, active low) empties the output register, drops any
// pending byte, sets the key index to zero and restores the registers to
// their defaults (key_length 1, all others 0).
module sequence_keyed_lsb_embedder #(
  parameter int MAX_KEY_CODES = ske_pkg::MAX_KEY_CODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [ske_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [ske_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: message_byte, chan_zero, chan_one, chan_two (lowest bits first).
  input  logic [ske_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: kind.
  input  logic                              in_tuser,
  // Output stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: out_chan_zero, out_chan_one, out_chan_two (lowest bits first).
  output logic [ske_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // tuser: bit_placed, capacity_error (lowest bit first).
  output logic [ske_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  localparam int KIDX_W = (MAX_KEY_CODES > 1) ? $clog2(MAX_KEY_CODES) : 1;
  localparam logic [ske_pkg::KEY_LEN_W-1:0] MAX_LEN = ske_pkg::KEY_LEN_W'(MAX_KEY_CODES);

  // Configuration registers.
  logic [ske_pkg::KEY_CODES_W-1:0] key_codes_r;
  logic [ske_pkg::KEY_LEN_W-1:0]   key_length_r;
  logic [ske_pkg::DIM_W-1:0]       image_width_r;
  logic [ske_pkg::DIM_W-1:0]       image_height_r;
  logic [ske_pkg::MSG_BYTES_W-1:0] message_bytes_r;

  // Embedding state.
  logic [ske_pkg::CHAN_W-1:0]      pend_byte_r, pend_byte_nxt;
  logic [ske_pkg::BITS_LEFT_W-1:0] bits_left_r, bits_left_nxt;
  logic [KIDX_W-1:0]               key_idx_r, key_idx_nxt;

  // Output register.
  logic                            out_valid_r;
  logic [ske_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [ske_pkg::OUT_TUSER_W-1:0] out_user_r;

  logic                            in_acc;
  logic                            is_pixel;
  logic [ske_pkg::KEY_LEN_W-1:0]   eff_len;
  logic [31:0]                     bits_needed;
  logic [31:0]                     pixels_have;
  logic                            cap_err;
  logic [1:0]                      code;
  logic [2:0]                      bit_sel;
  logic [ske_pkg::KEY_LEN_W-1:0]   idx_inc;
  logic [KIDX_W-1:0]               idx_wrap;
  ske_pkg::embed_ctl_t             ctl;
  logic [ske_pkg::CHAN_W-1:0]      res_zero, res_one, res_two;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_codes_r     <= '0;
      key_length_r    <= ske_pkg::KEY_LEN_W'(1);
      image_width_r   <= '0;
      image_height_r  <= '0;
      message_bytes_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ske_pkg::REG_KEY_CODES:     key_codes_r     <= cfg_wdata;
        ske_pkg::REG_KEY_LENGTH:    key_length_r    <= cfg_wdata[ske_pkg::KEY_LEN_W-1:0];
        ske_pkg::REG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata[ske_pkg::DIM_W-1:0];
        ske_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= cfg_wdata[ske_pkg::DIM_W-1:0];
        ske_pkg::REG_MESSAGE_BYTES: message_bytes_r <= cfg_wdata[ske_pkg::MSG_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: take a word whenever the output register is free or drains.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_pixel  = (in_tuser == ske_pkg::KIND_PIXEL);

  // Capacity check: message bits against pixel count.
  assign bits_needed = {message_bytes_r, 3'b000};
  assign pixels_have = 32'(image_width_r) * 32'(image_height_r);
  assign cap_err     = bits_needed > pixels_have;

  // Effective key length: zero counts as one, clamped to the key depth.
  always_comb begin
    eff_len = key_length_r;
    if (eff_len == '0) begin
      eff_len = ske_pkg::KEY_LEN_W'(1);
    end
    if (eff_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end
  end

  // Key code and message bit for the current pixel.
  assign code     = 2'(key_codes_r >> {key_idx_r, 1'b0});
  assign bit_sel  = 3'(bits_left_r - ske_pkg::BITS_LEFT_W'(1));
  assign idx_inc  = ske_pkg::KEY_LEN_W'(key_idx_r) + ske_pkg::KEY_LEN_W'(1);
  assign idx_wrap = (idx_inc >= eff_len) ? '0 : KIDX_W'(idx_inc);

  assign ctl.place   = !cap_err && (bits_left_r != '0);
  assign ctl.bit_val = pend_byte_r[bit_sel];
  assign ctl.code    = code;

  ske_embed u_embed (
    .chan_zero (in_tdata[15:8]),
    .chan_one  (in_tdata[23:16]),
    .chan_two  (in_tdata[31:24]),
    .ctl       (ctl),
    .res_zero  (res_zero),
    .res_one   (res_one),
    .res_two   (res_two)
  );

  // Next embedding state for an accepted word.
  always_comb begin
    pend_byte_nxt = pend_byte_r;
    bits_left_nxt = bits_left_r;
    key_idx_nxt   = key_idx_r;
    if (in_acc) begin
      if (!is_pixel) begin
        pend_byte_nxt = in_tdata[7:0];
        bits_left_nxt = ske_pkg::BYTE_BITS;
      end else if (ctl.place) begin
        bits_left_nxt = bits_left_r - ske_pkg::BITS_LEFT_W'(1);
        key_idx_nxt   = idx_wrap;
      end
    end
  end

  // Embedding state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_byte_r <= '0;
      bits_left_r <= '0;
      key_idx_r   <= '0;
    end else begin
      pend_byte_r <= pend_byte_nxt;
      bits_left_r <= bits_left_nxt;
      key_idx_r   <= key_idx_nxt;
    end
  end

  // Output register valid: loaded by a pixel, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && is_pixel) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_acc && is_pixel) begin
      out_data_r <= {res_two, res_one, res_zero};
      out_user_r <= {cap_err, ctl.place};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/core/ske_checker.sv
// Port-level checker of the sequence-keyed LSB embedder, bound to the top.
// Depends on ske_pkg and on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module ske_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [ske_pkg::IN_TDATA_W-1:0]    in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ske_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [ske_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  logic pix_acc;

  assign pix_acc = in_tvalid && in_tready && (in_tuser == ske_pkg::KIND_PIXEL);

  // A stalled result stays offered.
  `ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)

  // A pixel that hits the capacity error never carries a message bit.
  `ASSERT_RST(a_err_no_bit, clk, rst_n, out_tvalid && out_tuser[1] |-> !out_tuser[0])

  // Every accepted pixel shows up as a result in the next cycle.
  `ASSERT_RST(a_pix_result, clk, rst_n, pix_acc |=> out_tvalid)

  // A pixel without a placed bit passes through unchanged.
  `ASSERT_RST(a_pass_through, clk, rst_n,
    pix_acc |=> (out_tuser[0] || (out_tdata == $past(in_tdata[31:8]))))

  // The input side is always ready while no result is held.
  `ASSERT_ALWAYS(a_ready_free, clk, !rst_n || out_tvalid || in_tready)

endmodule

bind sequence_keyed_lsb_embedder ske_checker u_ske_checker (.*);

FILE: test/embed_checker.sv
// Checker for the sequence-keyed LSB embedder: watches the configuration
// port and both stream channels, predicts every output word and compares it.
// Depends on ske_pkg for widths, item kinds and register indexes.
module embed_checker
  import ske_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0][CHAN_W-1:0] chans;
    logic                   placed;
    logic                   cap_err;
  } pixel_result_t;

  // Shadow copy of the configuration registers.
  logic [KEY_CODES_W-1:0] key_codes_r;
  logic [KEY_LEN_W-1:0]   key_len_r;
  logic [DIM_W-1:0]       width_r;
  logic [DIM_W-1:0]       height_r;
  logic [MSG_BYTES_W-1:0] msg_bytes_r;

  // Shadow copy of the embedding state.
  logic [7:0]             held_byte;
  logic [BITS_LEFT_W-1:0] bits_to_place;
  logic [4:0]             key_pos;

  pixel_result_t expected_pixels[$];

  initial mismatches = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("embed_checker: mismatch at %0t ns: %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got)
      report_mismatch($sformatf("%s expected %0h got %0h", field, want, got));
  endtask

  // Works out the effect of one accepted input word on the shadow state and
  // queues the output word that a pixel gives.
  task automatic predict_word(input logic kind, input logic [IN_TDATA_W-1:0] data);
    pixel_result_t res;
    logic [1:0]    code;
    int unsigned   chan_sel;
    int unsigned   bit_pos;
    int unsigned   next_pos;
    int unsigned   eff_len;
    logic [63:0]   need;
    logic [63:0]   have;
    if (kind == KIND_BYTE) begin
      // A new byte replaces whatever bits were still pending.
      held_byte = data[7:0];
      bits_to_place = BYTE_BITS;
    end else begin
      res.chans = data[IN_TDATA_W-1:CHAN_W];
      need = 64'(msg_bytes_r) * 64'd8;
      have = 64'(width_r) * 64'(height_r);
      res.cap_err = (need > have);
      res.placed = 1'b0;
      if (!res.cap_err && bits_to_place != 0) begin
        // Key code: bit 1 selects channel 2, else bit 0 is the channel;
        // bit 0 set writes bit position 0, otherwise position 1.
        code = key_codes_r[2*key_pos +: 2];
        chan_sel = code[1] ? 2 : 32'(code[0]);
        bit_pos = code[0] ? 0 : 1;
        res.chans[chan_sel][bit_pos] = held_byte[3'(bits_to_place - BITS_LEFT_W'(1))];
        bits_to_place = bits_to_place - BITS_LEFT_W'(1);
        // A key length of zero acts as one, and lengths past the table size
        // are clamped to it.
        if (key_len_r == 0)
          eff_len = 1;
        else if (key_len_r > MAX_KEY_CODES_DEF)
          eff_len = MAX_KEY_CODES_DEF;
        else
          eff_len = 32'(key_len_r);
        next_pos = 32'(key_pos) + 1;
        if (next_pos >= eff_len)
          next_pos = 0;
        key_pos = 5'(next_pos);
        res.placed = 1'b1;
      end
      expected_pixels.push_back(res);
    end
  endtask

  // Sample all channels at the clock edge, compare first, then predict.
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      key_codes_r = '0;
      key_len_r = KEY_LEN_W'(1);
      width_r = '0;
      height_r = '0;
      msg_bytes_r = '0;
      held_byte = '0;
      bits_to_place = '0;
      key_pos = '0;
      expected_pixels.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_KEY_CODES:     key_codes_r = cfg_wdata[KEY_CODES_W-1:0];
          REG_KEY_LENGTH:    key_len_r = cfg_wdata[KEY_LEN_W-1:0];
          REG_IMAGE_WIDTH:   width_r = cfg_wdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT:  height_r = cfg_wdata[DIM_W-1:0];
          REG_MESSAGE_BYTES: msg_bytes_r = cfg_wdata[MSG_BYTES_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("output word with no pixel outstanding");
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_chan_zero", want.chans[0], out_tdata[7:0]);
          check_field("out_chan_one", want.chans[1], out_tdata[15:8]);
          check_field("out_chan_two", want.chans[2], out_tdata[23:16]);
          check_field("bit_placed", 8'(want.placed), 8'(out_tuser[0]));
          check_field("capacity_error", 8'(want.cap_err), 8'(out_tuser[1]));
        end
      end
      if (in_tvalid && in_tready)
        predict_word(in_tuser, in_tdata);
      outstanding <= expected_pixels.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Top of the embedder testbench: clock, reset, configuration phases, input
// and output stream drivers and the verdict.
// Depends on ske_pkg, the sequence_keyed_lsb_embedder RTL and embed_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ske_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int TIMEOUT_NS   = 2000000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int   mismatches;
  int   pixels_outstanding;
  int   words_sent;
  int   stall_ask;
  logic quiet;

  sequence_keyed_lsb_embedder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  embed_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (pixels_outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high
  // when no gap follows, so back-to-back words need no extra edge.
  task automatic send_word(input logic kind, input logic [IN_TDATA_W-1:0] data);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted pixel has come out, then let
  // the stream idle before the next step.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pixels_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] codes, input logic [5:0] len,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [28:0] msg);
    program_reg(REG_KEY_CODES, codes);
    program_reg(REG_KEY_LENGTH, 64'(len));
    program_reg(REG_IMAGE_WIDTH, 64'(w));
    program_reg(REG_IMAGE_HEIGHT, 64'(h));
    program_reg(REG_MESSAGE_BYTES, 64'(msg));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Per-phase settings: the first phases pin the key-length extremes and the
  // all-ones and all-zeros key tables; later ones are random. A few phases
  // push the message one byte past the image capacity.
  task automatic random_config(input int phase);
    logic [63:0] codes;
    logic [5:0]  len;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] wh;
    logic [28:0] msg;
    codes = {$urandom, $urandom};
    case (phase)
      0: len = 6'd0;
      1: len = 6'd63;
      2: begin
        len = 6'd32;
        codes = '1;
      end
      3: begin
        len = 6'd1;
        codes = '0;
      end
      default: begin
        if ($urandom_range(0, 9) == 0)
          len = 6'($urandom_range(33, 63));
        else
          len = 6'($urandom_range(1, 32));
      end
    endcase
    w = 16'($urandom);
    h = 16'($urandom);
    wh = 32'(w) * 32'(h);
    if ($urandom_range(0, 6) == 0)
      msg = 29'(wh / 8 + 1);
    else
      msg = 29'($urandom_range(0, wh / 8));
    set_config(codes, len, w, h, msg);
  endtask

  // Mostly a byte followed by its eight pixels; the rest are cut-short
  // messages, stray pixels and bytes that overwrite each other.
  task automatic send_sequence();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send_word(KIND_BYTE, $urandom);
      repeat (8) send_word(KIND_PIXEL, $urandom);
    end else if (r < 82) begin
      send_word(KIND_BYTE, $urandom);
      n = $urandom_range(0, 7);
      repeat (n) send_word(KIND_PIXEL, $urandom);
    end else if (r < 92) begin
      n = $urandom_range(1, 4);
      repeat (n) send_word(KIND_PIXEL, $urandom);
    end else begin
      send_word(KIND_BYTE, $urandom);
      send_word(KIND_BYTE, $urandom);
      n = $urandom_range(1, 9);
      repeat (n) send_word(KIND_PIXEL, $urandom);
    end
  endtask

  // Output side: random ready, with one long hold-off per request so the
  // output register fills and the block pushes back on its input.
  initial begin
    int          stall_seen;
    int unsigned hold;
    stall_seen = 0;
    out_tready = 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (stall_ask != stall_seen) begin
        stall_seen = stall_ask;
        hold = STALL_CYCLES;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase;
    int phase_end;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_BYTE;
    quiet = 1'b0;
    stall_ask = 0;
    words_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: a pixel with nothing pending, then one bit placed
    // under key code 0.
    send_word(KIND_PIXEL, 32'hFFFFFF00);
    send_word(KIND_BYTE, 32'h00000080);
    send_word(KIND_PIXEL, 32'h00000000);
    drain_results();

    // All four key codes in turn, with the largest message that still fits the image.
    set_config(64'hE4E4_E4E4_E4E4_E4E4, 6'd4, 16'hFFFF, 16'hFFFF, 29'd536854528);
    send_word(KIND_BYTE, 32'h000000A5);
    for (int i = 0; i < 8; i++)
      send_word(KIND_PIXEL, i[0] ? 32'hFFFFFFFF : 32'h00000000);
    // A byte load while bits are pending drops the rest of the old byte.
    send_word(KIND_BYTE, 32'hFFFFFFFF);
    send_word(KIND_PIXEL, 32'h00000000);
    send_word(KIND_PIXEL, 32'hFFFFFFFF);
    send_word(KIND_BYTE, 32'h00000000);
    send_word(KIND_PIXEL, 32'hFFFFFFFF);
    send_word(KIND_PIXEL, 32'h00000000);
    drain_results();

    // Largest message: over capacity, pixels pass and the byte still loads.
    set_config(64'hE4E4_E4E4_E4E4_E4E4, 6'd4, 16'hFFFF, 16'hFFFF, 29'h1FFFFFFF);
    send_word(KIND_BYTE, 32'h0000003C);
    send_word(KIND_PIXEL, 32'h5AA5C300);
    send_word(KIND_PIXEL, 32'hA55A3CFF);
    drain_results();

    // Message bits equal to pixel count is still within capacity.
    set_config(64'hE4E4_E4E4_E4E4_E4E4, 6'd4, 16'd8, 16'd1, 29'd1);
    repeat (4) send_word(KIND_PIXEL, $urandom);
    drain_results();

    // Random phases, each under its own settings.
    words_sent = 0;
    phase = 0;
    while (words_sent < RANDOM_ITEMS) begin
      random_config(phase);
      if (phase == 5 || phase == 12) begin
        stall_ask <= stall_ask + 1;
        quiet <= 1'b1;
      end else begin
        quiet <= ($urandom_range(0, 4) == 0);
      end
      phase_end = words_sent + $urandom_range(20, 80);
      while (words_sent < phase_end)
        send_sequence();
      drain_results();
      phase++;
    end

    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
